[src/grc_pkg.sv]
// Shared constants, types and helpers for the greedy rectangle cover block.
package grc_pkg;

  localparam int MAX_COLUMNS_DEF = 8;
  localparam int MAX_ROWS_DEF    = 8;
  localparam int IDX_W           = 3;
  localparam int DIM_W           = 4;
  localparam int TILE_W          = 8;
  localparam int RESULT_LIMIT    = 32;
  localparam int COUNT_W         = 6;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Register indexes on the configuration port.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef struct packed {
    logic             rect_found;
    logic [IDX_W-1:0] start_column;
    logic [IDX_W-1:0] start_row;
    logic [IDX_W-1:0] end_column;
    logic [IDX_W-1:0] end_row;
    logic             final_rect;
  } rect_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic             restart;
    logic [DIM_W-1:0] columns;
    logic [DIM_W-1:0] rows;
  } load_cfg_t;

  // A dimension of zero acts as one, any value above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

[src/grc_if.sv]
// Handshake interfaces for the tile input channel and the rectangle result channel.
interface grc_tile_if;
  import grc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_value;
  modport source (output valid, output tile_value, input ready);
  modport sink (input valid, input tile_value, output ready);
endinterface

interface grc_rect_if;
  import grc_pkg::*;
  logic             valid;
  logic             ready;
  logic             rect_found;
  logic [IDX_W-1:0] start_column;
  logic [IDX_W-1:0] start_row;
  logic [IDX_W-1:0] end_column;
  logic [IDX_W-1:0] end_row;
  logic             final_rect;
  modport source (output valid, output rect_found, output start_column, output start_row,
                  output end_column, output end_row, output final_rect, input ready);
  modport sink (input valid, input rect_found, input start_column, input start_row,
                input end_column, input end_row, input final_rect, output ready);
endinterface

[src/grc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/grc_queue.sv]
// Small FIFO that carries finished grid rows from the loader to the cover engine.
module grc_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = grc_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       pop_data,
  output grc_pkg::queue_status_t status
);
  import grc_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign pop_data     = mem[rd_ptr];
  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[src/grc_front.sv]
// Loader: takes tiles in row-major order and packs each grid row into one queue entry.
module grc_front #(
  parameter int MAX_COLUMNS = grc_pkg::MAX_COLUMNS_DEF,
  localparam int ENTRY_W = grc_pkg::IDX_W + grc_pkg::DIM_W + 1 + MAX_COLUMNS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  grc_pkg::load_cfg_t          cfg,
  input  logic                        tile_valid,
  output logic                        tile_ready,
  input  logic [grc_pkg::TILE_W-1:0]  tile_value,
  input  grc_pkg::queue_status_t      q_stat,
  output logic                        q_push,
  output logic [ENTRY_W-1:0]          q_entry
);
  import grc_pkg::*;

  logic [IDX_W-1:0]       col;
  logic [IDX_W-1:0]       row;
  logic [MAX_COLUMNS-1:0] acc;
  logic [MAX_COLUMNS-1:0] word_next;
  logic                   accept;
  logic                   row_end;
  logic                   grid_end;

  assign tile_ready = !q_stat.full;
  assign accept     = tile_valid && tile_ready;
  assign word_next  = acc | (MAX_COLUMNS'(|tile_value) << col);
  assign row_end    = (DIM_W'(col) + 1'b1) == cfg.columns;
  assign grid_end   = row_end && ((DIM_W'(row) + 1'b1) == cfg.rows);
  assign q_push     = accept && row_end;
  assign q_entry    = {row, cfg.rows, grid_end, word_next};

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col <= '0;
      row <= '0;
      acc <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        acc <= '0;
        row <= grid_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
        acc <= word_next;
      end
    end
  end

endmodule

[src/grc_back.sv]
// Cover engine: stores rows in the grid RAM and peels off rectangles in row-major order.
module grc_back #(
  parameter int MAX_COLUMNS = grc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = grc_pkg::MAX_ROWS_DEF,
  localparam int ENTRY_W = grc_pkg::IDX_W + grc_pkg::DIM_W + 1 + MAX_COLUMNS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  grc_pkg::queue_status_t q_stat,
  output logic                   q_pop,
  input  logic [ENTRY_W-1:0]     q_entry,
  input  logic                   out_ready,
  output logic                   out_valid,
  output grc_pkg::rect_t         out_rect
);
  import grc_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CHK = 3'd2;
  localparam logic [2:0] S_DOWN_RD  = 3'd3;
  localparam logic [2:0] S_DOWN_CHK = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;
  localparam logic [2:0] S_END      = 3'd6;

  logic [2:0]             state;
  logic [IDX_W-1:0]       scan_row;
  logic [IDX_W-1:0]       sr;
  logic [IDX_W-1:0]       er;
  logic [IDX_W-1:0]       sc;
  logic [IDX_W-1:0]       ec;
  logic [MAX_COLUMNS-1:0] mask;
  logic [DIM_W-1:0]       rows_run;
  logic [COUNT_W-1:0]     count;
  logic [COUNT_W-1:0]     count_inc;
  rect_t                  pend;
  logic                   pend_v;
  logic                   out_free;
  logic [IDX_W-1:0]       er_inc;
  logic                   emit;
  rect_t                  last_rect;

  logic [MAX_COLUMNS-1:0] e_word;
  logic                   e_last;
  logic [DIM_W-1:0]       e_rows;
  logic [IDX_W-1:0]       e_row;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [MAX_COLUMNS-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [MAX_COLUMNS-1:0] ram_rdata;

  logic                   f_found;
  logic                   f_run;
  logic [IDX_W-1:0]       f_sc;
  logic [IDX_W-1:0]       f_ec;
  logic [MAX_COLUMNS-1:0] f_mask;
  logic                   row_full;

  assign e_word = q_entry[MAX_COLUMNS-1:0];
  assign e_last = q_entry[MAX_COLUMNS];
  assign e_rows = q_entry[MAX_COLUMNS+DIM_W:MAX_COLUMNS+1];
  assign e_row  = q_entry[ENTRY_W-1 -: IDX_W];

  assign er_inc    = er + 1'b1;
  assign count_inc = count + 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign row_full  = (ram_rdata & mask) == mask;
  assign q_pop     = (state == S_IDLE) && !q_stat.empty;

  // A result goes out when a held rectangle is replaced or when the run closes.
  assign emit = ((state == S_DONE) && pend_v && out_free) || ((state == S_END) && out_free);

  // The closing result: the held rectangle, or the empty-grid marker.
  always_comb begin
    if (pend_v) begin
      last_rect = pend;
    end else begin
      last_rect = '0;
    end
    last_rect.final_rect = 1'b1;
  end

  grc_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // First set bit of the row and the run of set bits that follows it.
  always_comb begin
    f_found = 1'b0;
    f_run   = 1'b0;
    f_sc    = '0;
    f_ec    = '0;
    f_mask  = '0;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (!f_found && ram_rdata[c]) begin
        f_found = 1'b1;
        f_run   = 1'b1;
        f_sc    = IDX_W'(c);
      end else if (f_run && !ram_rdata[c]) begin
        f_run = 1'b0;
      end
      if (f_run) begin
        f_mask[c] = 1'b1;
        f_ec      = IDX_W'(c);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_row[AW-1:0];
    ram_wdata = '0;
    ram_raddr = scan_row[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (!q_stat.empty) begin
          ram_we    = 1'b1;
          ram_waddr = e_row[AW-1:0];
          ram_wdata = e_word;
        end
      end
      S_SCAN_CHK: begin
        if (f_found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~f_mask;
        end
      end
      S_DOWN_RD: begin
        ram_raddr = er_inc[AW-1:0];
      end
      S_DOWN_CHK: begin
        if (row_full) begin
          ram_we    = 1'b1;
          ram_waddr = er_inc[AW-1:0];
          ram_wdata = ram_rdata & ~mask;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty && e_last) begin
            rows_run <= e_rows;
            scan_row <= '0;
            count    <= '0;
            pend_v   <= 1'b0;
            state    <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (f_found) begin
            sc    <= f_sc;
            ec    <= f_ec;
            mask  <= f_mask;
            sr    <= scan_row;
            er    <= scan_row;
            state <= ((DIM_W'(scan_row) + 1'b1) < rows_run) ? S_DOWN_RD : S_DONE;
          end else if ((DIM_W'(scan_row) + 1'b1) < rows_run) begin
            scan_row <= scan_row + 1'b1;
            state    <= S_SCAN_RD;
          end else begin
            state <= S_END;
          end
        end
        S_DOWN_RD: begin
          state <= S_DOWN_CHK;
        end
        S_DOWN_CHK: begin
          if (row_full) begin
            er    <= er_inc;
            state <= ((DIM_W'(er_inc) + 1'b1) < rows_run) ? S_DOWN_RD : S_DONE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              out_rect <= pend;
            end
            pend.rect_found   <= 1'b1;
            pend.start_column <= sc;
            pend.start_row    <= sr;
            pend.end_column   <= ec;
            pend.end_row      <= er;
            pend.final_rect   <= 1'b0;
            pend_v            <= 1'b1;
            count             <= count_inc;
            state <= (count_inc == COUNT_W'(RESULT_LIMIT)) ? S_END : S_SCAN_RD;
          end
        end
        S_END: begin
          if (out_free) begin
            out_rect <= last_rect;
            pend_v   <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/greedy_rectangle_cover.sv]
// Top level of the greedy rectangle cover block: configuration port, loader and cover engine.
//
//   Channel   Direction  Handshake           Payload
//   tiles     in         valid / ready       tile_value, one cell in row-major order
//   rects     out        valid / ready       rect_found, start/end column and row, final_rect
//   config    in         APB psel / penable  grid_columns at 0x0, grid_rows at 0x4
//
// Tiles load one per cycle while the row queue has room; each finished row goes into the
// queue, so the loader only stalls when the cover engine falls two rows behind.
// The cover engine takes a read state and a check state for each row it scans (grid RAM
// registered read) and for each row a rectangle grows down, S_DONE to commit each
// rectangle and S_END to send the closing result, plus any output stall.
// Reset is synchronous and needs no clearing pass; the grid RAM is only read after a
// whole grid has been loaded into it.
// A stalled result request holds the engine; the loader keeps filling the queue meanwhile.
module greedy_rectangle_cover #(
  parameter int MAX_COLUMNS = grc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = grc_pkg::MAX_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  grc_tile_if.sink          tiles,
  grc_rect_if.source        rects
);
  import grc_pkg::*;

  localparam int ENTRY_W = IDX_W + DIM_W + 1 + MAX_COLUMNS;

  logic [DIM_W-1:0] grid_columns;
  logic [DIM_W-1:0] grid_rows;
  logic             cfg_write;
  load_cfg_t        load_cfg;
  queue_status_t    q_stat;
  logic             q_push;
  logic             q_pop;
  logic [ENTRY_W-1:0] q_push_entry;
  logic [ENTRY_W-1:0] q_pop_entry;
  rect_t            out_rect;

  // Registers are decoded on the word address only; any write restarts the grid load.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_ROWS) ? 32'(grid_rows) : 32'(grid_columns);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= DIM_RESET;
      grid_rows    <= DIM_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_COLUMNS) begin
        grid_columns <= pwdata[DIM_W-1:0];
      end else begin
        grid_rows <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign load_cfg.restart = cfg_write;
  assign load_cfg.columns = clamp_dim(grid_columns, DIM_W'(MAX_COLUMNS));
  assign load_cfg.rows    = clamp_dim(grid_rows, DIM_W'(MAX_ROWS));

  grc_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (load_cfg),
    .tile_valid (tiles.valid),
    .tile_ready (tiles.ready),
    .tile_value (tiles.tile_value),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_entry    (q_push_entry)
  );

  grc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_entry),
    .pop       (q_pop),
    .pop_data  (q_pop_entry),
    .status    (q_stat)
  );

  grc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .q_entry   (q_pop_entry),
    .out_ready (rects.ready),
    .out_valid (rects.valid),
    .out_rect  (out_rect)
  );

  assign rects.rect_found   = out_rect.rect_found;
  assign rects.start_column = out_rect.start_column;
  assign rects.start_row    = out_rect.start_row;
  assign rects.end_column   = out_rect.end_column;
  assign rects.end_row      = out_rect.end_row;
  assign rects.final_rect   = out_rect.final_rect;

  // The loader never pushes a row into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("row pushed into a full queue");

  // The empty-grid result is always the last one of its run.
  a_empty_final: assert property (@(posedge clk) disable iff (rst)
    (rects.valid && !rects.rect_found) |-> rects.final_rect)
    else $error("empty-grid result not marked final");

  // A rectangle never ends before it starts.
  a_rect_order: assert property (@(posedge clk) disable iff (rst)
    (rects.valid && rects.rect_found) |->
      (rects.start_column <= rects.end_column) && (rects.start_row <= rects.end_row))
    else $error("rectangle corners out of order");

  // Reset drops any pending result request.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rects.valid)
    else $error("result valid right after reset");

endmodule
